// ----- rtl/chs_pkg.sv -----
// chs_pkg: shared types and fixed-point constants for the cubic hermite sampler
// no dependencies; used by chs_lane, chs_merge and the top level
package chs_pkg;

  localparam int FieldW = 32;           // width of point, slope and output fields
  localparam int CoefW  = 38;           // hermite coefficients stay below 2^37
  localparam int AccW   = 41;           // horner partial sums stay below 2^40
  localparam int TW     = 18;           // t in q0.16, up to 1.0, plus headroom
  localparam int StepW  = 17;
  localparam int SegW   = 7;
  localparam logic [TW-1:0] TOne = 18'd65536;

  // register indexes
  localparam logic [1:0] RegNumSegments = 2'd0;
  localparam logic [1:0] RegTStep       = 2'd1;

  // one issued sample as seen by the lanes
  typedef struct packed {
    logic          adv;
    logic          load;
    logic [TW-1:0] t;
  } lane_ctl_t;

endpackage

// ----- rtl/chs_lane.sv -----
// chs_lane: one axis; coefficient solve and a three stage horner pipeline
// depends on chs_pkg
module chs_lane #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                               clk,
  input  chs_pkg::lane_ctl_t                 ctl,
  input  logic signed [chs_pkg::FieldW-1:0]  p0,
  input  logic signed [chs_pkg::FieldW-1:0]  d0,
  input  logic signed [chs_pkg::FieldW-1:0]  p1,
  input  logic signed [chs_pkg::FieldW-1:0]  d1,
  output logic signed [chs_pkg::FieldW-1:0]  res
);
  localparam logic signed [63:0] SatHi = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] SatLo = -SatHi - 64'sd1;
  localparam int PW = chs_pkg::AccW + chs_pkg::TW;

  logic signed [chs_pkg::CoefW-1:0] ca, cb, cc, cd;
  logic signed [chs_pkg::CoefW-1:0] p0e, d0e, p1e, d1e;
  logic signed [chs_pkg::AccW-1:0]  acc1, acc2;
  logic [chs_pkg::TW-1:0]           t1, t2;
  logic signed [PW-1:0]             prod1, prod2, prod3;
  logic signed [chs_pkg::AccW-1:0]  sum3;
  logic signed [63:0]               sum3e;

  // sign extension of the stored and incoming point
  assign p0e = chs_pkg::CoefW'(p0);
  assign d0e = chs_pkg::CoefW'(d0);
  assign p1e = chs_pkg::CoefW'(p1);
  assign d1e = chs_pkg::CoefW'(d1);

  // coefficients latched when an interval starts
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ca <= p0e;
      cb <= d0e;
      cc <= 38'sd3 * (p1e - p0e) - 38'sd2 * d0e - d1e;
      cd <= 38'sd2 * (p0e - p1e) + d0e + d1e;
    end
  end

  // products, floor by arithmetic shift
  assign prod1 = PW'(cd) * PW'($signed({1'b0, ctl.t}));
  assign prod2 = PW'(acc1) * PW'($signed({1'b0, t1}));
  assign prod3 = PW'(acc2) * PW'($signed({1'b0, t2}));
  assign sum3  = chs_pkg::AccW'(prod3 >>> 16) + chs_pkg::AccW'(ca);
  assign sum3e = 64'(sum3);

  // horner stages
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      acc1 <= chs_pkg::AccW'(prod1 >>> 16) + chs_pkg::AccW'(cc);
      t1   <= ctl.t;
      acc2 <= chs_pkg::AccW'(prod2 >>> 16) + chs_pkg::AccW'(cb);
      t2   <= t1;
      if (sum3e > SatHi) res <= SatHi[chs_pkg::FieldW-1:0];
      else if (sum3e < SatLo) res <= SatLo[chs_pkg::FieldW-1:0];
      else res <= sum3e[chs_pkg::FieldW-1:0];
    end
  end
endmodule

// ----- rtl/chs_merge.sv -----
// chs_merge: output register that joins the three lane results into one request
// depends on chs_pkg
module chs_merge (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_v,
  input  logic                              in_last,
  input  logic signed [chs_pkg::FieldW-1:0] rx,
  input  logic signed [chs_pkg::FieldW-1:0] ry,
  input  logic signed [chs_pkg::FieldW-1:0] rz,
  output logic                              out_valid,
  output logic signed [chs_pkg::FieldW-1:0] out_x,
  output logic signed [chs_pkg::FieldW-1:0] out_y,
  output logic signed [chs_pkg::FieldW-1:0] out_z,
  output logic                              last_sample
);
  // valid flag
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= in_v;
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_x       <= rx;
      out_y       <= ry;
      out_z       <= rz;
      last_sample <= in_last;
    end
  end
endmodule

// ----- rtl/cubic_hermite_segment_sampler.sv -----
// cubic_hermite_segment_sampler: top level, sequencer, three axis lanes, merge
// depends on chs_pkg, chs_lane, chs_merge
//
//  channel  | handshake            | payload
//  input    | in_valid / in_stall  | point_x/y/z, slope_x/y/z, new_curve
//  output   | out_valid / out_stall| out_x/y/z, last_sample
//  config   | cfg_we               | cfg_index, cfg_data
//
// an interval emits num_segments samples (clamped to 1..MAX_SEGMENTS), one
// per cycle unless the output stalls, once the issue register, three horner
// stages and output register have filled. the next point is taken once the
// sequencer and lane stages have drained; a curve start point emits nothing.
// reset is synchronous; a stall on a valid output freezes the pipeline.
module cubic_hermite_segment_sampler #(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_WIDTH  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [chs_pkg::FieldW-1:0] point_x,
  input  logic signed [chs_pkg::FieldW-1:0] point_y,
  input  logic signed [chs_pkg::FieldW-1:0] point_z,
  input  logic signed [chs_pkg::FieldW-1:0] slope_x,
  input  logic signed [chs_pkg::FieldW-1:0] slope_y,
  input  logic signed [chs_pkg::FieldW-1:0] slope_z,
  input  logic                              new_curve,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [chs_pkg::FieldW-1:0] out_x,
  output logic signed [chs_pkg::FieldW-1:0] out_y,
  output logic signed [chs_pkg::FieldW-1:0] out_z,
  output logic                              last_sample,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [chs_pkg::StepW-1:0]         cfg_data
);
  logic [chs_pkg::SegW-1:0]  num_segments;
  logic [chs_pkg::StepW-1:0] t_step;
  logic signed [chs_pkg::FieldW-1:0] prev_p [3];
  logic signed [chs_pkg::FieldW-1:0] prev_d [3];
  logic signed [chs_pkg::FieldW-1:0] cur_p [3];
  logic signed [chs_pkg::FieldW-1:0] cur_d [3];
  logic signed [chs_pkg::FieldW-1:0] res [3];
  logic have_previous, busy, adv, accept, emit;
  logic [chs_pkg::SegW-1:0] k, n_lat, n_eff;
  logic [chs_pkg::TW-1:0]   tacc, tacc_next, step_sat, t_issue;
  logic v_issue, v1, v2, v3, l_issue, l1, l2, l3;
  chs_pkg::lane_ctl_t ctl;

  assign cur_p[0] = point_x;
  assign cur_p[1] = point_y;
  assign cur_p[2] = point_z;
  assign cur_d[0] = slope_x;
  assign cur_d[1] = slope_y;
  assign cur_d[2] = slope_z;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = busy || v_issue || v1 || v2 || v3;
  assign accept   = in_valid && !in_stall;
  assign emit     = accept && !new_curve && have_previous;

  // clamp of the segment count
  always_comb begin
    if (num_segments == '0) n_eff = chs_pkg::SegW'(1);
    else if (int'(num_segments) > MAX_SEGMENTS) n_eff = chs_pkg::SegW'(MAX_SEGMENTS);
    else n_eff = num_segments;
  end

  // saturated parameter steps
  always_comb begin
    step_sat  = (chs_pkg::TW'(t_step) > chs_pkg::TOne) ? chs_pkg::TOne
                                                        : chs_pkg::TW'(t_step);
    tacc_next = tacc + chs_pkg::TW'(t_step);
    if (tacc_next > chs_pkg::TOne) tacc_next = chs_pkg::TOne;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_segments <= 7'd20;
      t_step       <= 17'd3277;
    end else if (cfg_we) begin
      if (cfg_index == chs_pkg::RegNumSegments) num_segments <= cfg_data[chs_pkg::SegW-1:0];
      else if (cfg_index == chs_pkg::RegTStep) t_step <= cfg_data;
    end
  end

  // previous point and slope
  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev_p[i] <= '0;
        prev_d[i] <= '0;
      end
    end else if (accept) begin
      have_previous <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        prev_p[i] <= cur_p[i];
        prev_d[i] <= cur_d[i];
      end
    end
  end

  // sample sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      v_issue <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (emit) begin
        busy  <= 1'b1;
        k     <= chs_pkg::SegW'(1);
        n_lat <= n_eff;
        tacc  <= step_sat;
      end
      if (adv) begin
        v1 <= v_issue;
        v2 <= v1;
        v3 <= v2;
        l1 <= l_issue;
        l2 <= l1;
        l3 <= l2;
        v_issue <= busy;
        if (busy) begin
          t_issue <= (k == n_lat) ? chs_pkg::TOne : tacc;
          l_issue <= (k == n_lat);
          k       <= k + chs_pkg::SegW'(1);
          tacc    <= tacc_next;
          if (k == n_lat) busy <= 1'b0;
        end
      end
    end
  end

  assign ctl.adv  = adv;
  assign ctl.load = emit;
  assign ctl.t    = t_issue;

  // one lane per axis
  for (genvar g = 0; g < 3; g++) begin : g_lane
    chs_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane (
      .clk (clk),
      .ctl (ctl),
      .p0  (prev_p[g]),
      .d0  (prev_d[g]),
      .p1  (cur_p[g]),
      .d1  (cur_d[g]),
      .res (res[g])
    );
  end

  chs_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_v        (v3),
    .in_last     (l3),
    .rx          (res[0]),
    .ry          (res[1]),
    .rz          (res[2]),
    .out_valid   (out_valid),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .last_sample (last_sample)
  );

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |-> !busy && !v1 && !v2 && !v3) else $error("request taken while busy");
  a_emit_starts: assert property (@(posedge clk) disable iff (rst)
    emit |=> busy) else $error("interval did not start");
  a_stage_to_out: assert property (@(posedge clk) disable iff (rst)
    (v3 && adv) |=> out_valid) else $error("sample lost at merge");
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(v3) && $stable(v_issue))
    else $error("pipeline moved in stall");
endmodule
